[rtl/atf_pkg.sv]
package atf_pkg;

    localparam int MAX_PAYLOAD_DEF = 256;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Input item kinds.
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEST_HIGH = 2'd0;
    localparam logic [1:0] REG_DEST_LOW  = 2'd1;
    localparam logic [1:0] REG_ATTEMPTS  = 2'd2;

    // Frame constants.
    localparam logic [7:0]  BYTE_DELIM    = 8'h7E;
    localparam logic [7:0]  BYTE_TYPE     = 8'h10;
    localparam logic [7:0]  BYTE_ZERO     = 8'h00;
    localparam logic [7:0]  BYTE_NET_HI   = 8'hFF;
    localparam logic [7:0]  BYTE_NET_LO   = 8'hFE;
    localparam logic [7:0]  BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0]  BYTE_SLASH    = 8'h2F;
    localparam logic [7:0]  BYTE_RBRACKET = 8'h5D;
    localparam logic [7:0]  ASCII_ZERO    = 8'd48;
    localparam logic [7:0]  CSUM_BASE     = 8'hFF;
    localparam logic [15:0] LEN_OVERHEAD  = 16'd19;

    // Header positions.
    localparam logic [4:0] IDX_FIRST_SUMMED = 5'd3;
    localparam logic [4:0] IDX_HDR_LAST     = 5'd21;
    localparam logic [4:0] IDX_START_CSUM   = 5'd22;
    localparam logic [4:0] IDX_PAY_CSUM     = 5'd1;

    typedef struct packed {
        logic       kind;
        logic [3:0] attempt;
        logic [8:0] payload_len;
        logic [7:0] payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
    } t_out_item;

    // One work command handed from the front end to the back end.
    typedef struct packed {
        logic       is_start;
        logic       last;   // payload: checksum follows; start: empty payload
        logic [7:0] data;   // payload byte, or attempt digit for a start
        logic [8:0] len;    // saturated payload length for a start
    } t_cmd;

    typedef struct packed {
        logic [31:0] dest_high;
        logic [31:0] dest_low;
        logic [3:0]  attempts_total;
    } t_cfg;

endpackage

[rtl/atf_front.sv]
module atf_front #(
    parameter int P_MAX_PAYLOAD = atf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  atf_pkg::t_in_item  i_item,
    output logic               o_push,
    output atf_pkg::t_cmd      o_cmd
);
    import atf_pkg::*;

    logic [8:0] r_bytes_left;
    logic [8:0] n_bytes_left;
    logic [8:0] w_len_sat;

    always_comb begin
        if (32'(i_item.payload_len) > P_MAX_PAYLOAD) begin
            w_len_sat = 9'(P_MAX_PAYLOAD);
        end else begin
            w_len_sat = i_item.payload_len;
        end
    end

    // A start always opens a new frame; a payload byte counts only inside one.
    always_comb begin
        n_bytes_left = r_bytes_left;
        o_push       = 1'b0;
        o_cmd        = '0;
        if (i_accept) begin
            if (i_item.kind == KIND_START) begin
                o_push         = 1'b1;
                o_cmd.is_start = 1'b1;
                o_cmd.last     = (w_len_sat == 9'd0);
                o_cmd.data     = 8'(i_item.attempt) + ASCII_ZERO;
                o_cmd.len      = w_len_sat;
                n_bytes_left   = w_len_sat;
            end else if (r_bytes_left != 9'd0) begin
                o_push       = 1'b1;
                o_cmd.last   = (r_bytes_left == 9'd1);
                o_cmd.data   = i_item.payload_byte;
                n_bytes_left = r_bytes_left - 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
        end else begin
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

[rtl/atf_queue.sv]
module atf_queue #(
    parameter int P_DEPTH = atf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  atf_pkg::t_cmd  i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output atf_pkg::t_cmd  o_cmd,
    input  logic           i_pop
);
    import atf_pkg::*;

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_cmd          r_mem [P_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wptr;
    logic [PW-1:0] n_rptr;
    logic [CW-1:0] n_count;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(P_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(P_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("command popped from an empty queue");

endmodule

[rtl/atf_back.sv]
module atf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  atf_pkg::t_cfg      i_cfg,
    input  logic               i_cmd_valid,
    input  atf_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output atf_pkg::t_out_item o_out
);
    import atf_pkg::*;

    logic [4:0]  r_idx;
    logic [4:0]  n_idx;
    logic [7:0]  r_sum;
    logic [7:0]  n_sum;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [15:0] w_len_field;
    logic [7:0]  w_byte;
    logic        w_is_csum;
    logic        w_is_final;
    logic        w_step;

    assign w_len_field = 16'(i_cmd.len) + LEN_OVERHEAD;
    assign w_step      = i_cmd_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        if (i_cmd.is_start) begin
            w_is_csum  = (r_idx == IDX_START_CSUM);
            w_is_final = i_cmd.last ? (r_idx == IDX_START_CSUM) : (r_idx == IDX_HDR_LAST);
        end else begin
            w_is_csum  = (r_idx == IDX_PAY_CSUM);
            w_is_final = i_cmd.last ? (r_idx == IDX_PAY_CSUM) : (r_idx == 5'd0);
        end
    end

    always_comb begin
        w_byte = CSUM_BASE - r_sum;
        if (i_cmd.is_start) begin
            case (r_idx)
                5'd0:    w_byte = BYTE_DELIM;
                5'd1:    w_byte = w_len_field[15:8];
                5'd2:    w_byte = w_len_field[7:0];
                5'd3:    w_byte = BYTE_TYPE;
                5'd4:    w_byte = BYTE_ZERO;
                5'd5:    w_byte = i_cfg.dest_high[31:24];
                5'd6:    w_byte = i_cfg.dest_high[23:16];
                5'd7:    w_byte = i_cfg.dest_high[15:8];
                5'd8:    w_byte = i_cfg.dest_high[7:0];
                5'd9:    w_byte = i_cfg.dest_low[31:24];
                5'd10:   w_byte = i_cfg.dest_low[23:16];
                5'd11:   w_byte = i_cfg.dest_low[15:8];
                5'd12:   w_byte = i_cfg.dest_low[7:0];
                5'd13:   w_byte = BYTE_NET_HI;
                5'd14:   w_byte = BYTE_NET_LO;
                5'd15:   w_byte = BYTE_ZERO;
                5'd16:   w_byte = BYTE_ZERO;
                5'd17:   w_byte = BYTE_LBRACKET;
                5'd18:   w_byte = i_cmd.data;
                5'd19:   w_byte = BYTE_SLASH;
                5'd20:   w_byte = 8'(i_cfg.attempts_total) + ASCII_ZERO;
                5'd21:   w_byte = BYTE_RBRACKET;
                default: w_byte = CSUM_BASE - r_sum;
            endcase
        end else if (r_idx == 5'd0) begin
            w_byte = i_cmd.data;
        end
    end

    // The running sum restarts with every header and after every checksum.
    always_comb begin
        n_idx = r_idx;
        n_sum = r_sum;
        if (w_step) begin
            n_idx = w_is_final ? 5'd0 : r_idx + 5'd1;
            if (w_is_csum || (i_cmd.is_start && r_idx < IDX_FIRST_SUMMED)) begin
                n_sum = 8'd0;
            end else begin
                n_sum = r_sum + w_byte;
            end
        end
    end

    assign o_pop       = w_step && w_is_final;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out.frame_byte <= w_byte;
            r_out.last       <= w_is_csum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_sum <= n_sum;
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_START_CSUM)
        else $error("frame byte index out of range");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_is_csum |=> r_sum == 8'd0 && r_idx == 5'd0)
        else $error("checksum did not close the frame");

endmodule

[rtl/api_tx_request_framer_top.sv]
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      i_in  (t_in_item)
// out       output     o_out_valid / i_out_ready    o_out (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Every input transaction is taken while the command queue has room.
// The back end sends one frame byte per cycle while a command waits and the output is
// not stalled: 22 header bytes for a start, one byte for a payload byte, and one more
// for the checksum; the single byte lane of the output register sets that figure.
// Reset (synchronous, active low) clears queue and counters, loads config defaults.
// A stalled output holds the back end, and the input stalls only when the queue is full.
module api_tx_request_framer_top #(
    parameter int P_MAX_PAYLOAD = atf_pkg::MAX_PAYLOAD_DEF,
    parameter int P_QUEUE_DEPTH = atf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  atf_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output atf_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import atf_pkg::*;

    t_cfg r_cfg;
    logic w_in_accept;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_pop;

    // Configuration writes are always taken; an unknown index is ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_high      <= 32'd1286656;
            r_cfg.dest_low       <= 32'd1084742415;
            r_cfg.attempts_total <= 4'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEST_HIGH: r_cfg.dest_high      <= i_cfg_data;
                REG_DEST_LOW:  r_cfg.dest_low       <= i_cfg_data;
                REG_ATTEMPTS:  r_cfg.attempts_total <= i_cfg_data[3:0];
                default:       r_cfg                <= r_cfg;
            endcase
        end
    end

    // The front end needs one free queue slot for whatever it might push.
    assign o_in_ready  = !w_full;
    assign w_in_accept = i_in_valid && o_in_ready;

    atf_front #(
        .P_MAX_PAYLOAD(P_MAX_PAYLOAD)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_accept),
        .i_item   (i_in),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    atf_queue #(
        .P_DEPTH(P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_cmd),
        .i_pop   (w_pop)
    );

    atf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
